// File: rtl/timestamp_sorted_queue_core_macros.svh
// Assertion macros used by the queue core RTL.
// TSQ_ASSERT checks a property on every rising clock edge outside reset.
// TSQ_ASSERT_NORST checks a property on every rising clock edge, reset included.
`ifndef TIMESTAMP_SORTED_QUEUE_CORE_MACROS_SVH
`define TIMESTAMP_SORTED_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TSQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("queue assertion failed");
`define TSQ_ASSERT_NORST(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("queue assertion failed");
`else
`define TSQ_ASSERT(name, clk, rst_n, prop)
`define TSQ_ASSERT_NORST(name, clk, prop)
`endif

`endif

// File: rtl/tsq_pkg.sv
package tsq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned StampW       = 32;
  localparam int unsigned CodeW        = 32;
  localparam int unsigned OccW         = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [StampW-1:0] stamp;
    logic [CodeW-1:0]  packet_code;
  } tsq_item_t;

  typedef struct packed {
    status_e           status;
    logic [StampW-1:0] out_stamp;
    logic [CodeW-1:0]  out_code;
    logic [OccW-1:0]   occupancy;
  } tsq_result_t;

  // One stored packet
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [CodeW-1:0]  code;
  } tsq_entry_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic       insert;
    logic       remove;
    tsq_entry_t entry;
  } tsq_ctrl_t;

endpackage

// File: rtl/timestamp_sorted_queue_core.sv
// Channel   Ports                 Handshake
// --------  --------------------  ------------------------------------------
// command   cmd_i                 start high and busy low at a rising edge
// result    result_o              done_o high for one cycle, always taken
//
// One transaction per cycle: every cell compares its stamp with the new one
// in parallel and shifts by one place, so busy stays low.
// The result appears on the cycle after the command is taken.
// Reset empties the queue at once (count cleared); no clearing pass is run.
// The receiver cannot stall; results are never held back.
`include "timestamp_sorted_queue_core_macros.svh"

module timestamp_sorted_queue_core #(
  parameter int unsigned DEPTH = tsq_pkg::DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tsq_pkg::tsq_item_t   cmd_i,
  output logic                 done_o,
  output tsq_pkg::tsq_result_t result_o
);
  import tsq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic             accept;
  logic             full, empty;
  logic [CntW-1:0]  count_q, count_d;
  tsq_ctrl_t        ctrl;
  logic             done_q;
  tsq_result_t      result_q, result_d;
  logic [DEPTH-1:0] gt;
  tsq_entry_t       entry [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  // Broadcast the transaction to the chain
  always_comb begin
    ctrl.insert      = accept && (cmd_i.command == CMD_INSERT) && !full;
    ctrl.remove      = accept && (cmd_i.command == CMD_REMOVE) && !empty;
    ctrl.entry.stamp = cmd_i.stamp;
    ctrl.entry.code  = cmd_i.packet_code;
  end

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       occupied;
    logic       left_gt;
    tsq_entry_t left, right;

    assign occupied = (CntW'(i) < count_q);
    if (i == 0) begin : g_head
      assign left_gt = 1'b0;
      assign left    = ctrl.entry;
    end else begin : g_body
      assign left_gt = gt[i-1];
      assign left    = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = entry[i];
    end else begin : g_inner
      assign right = entry[i+1];
    end

    tsq_cell u_cell (
      .clk_i      (clk_i),
      .occupied_i (occupied),
      .ctrl_i     (ctrl),
      .left_gt_i  (left_gt),
      .left_i     (left),
      .right_i    (right),
      .gt_o       (gt[i]),
      .entry_o    (entry[i])
    );
  end

  // Track occupancy and form the result
  always_comb begin
    count_d            = count_q;
    result_d.status    = ST_INSERTED;
    result_d.out_stamp = '0;
    result_d.out_code  = '0;
    if (ctrl.insert) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.remove) begin
      count_d            = count_q - 1'b1;
      result_d.status    = ST_REMOVED;
      result_d.out_stamp = entry[0].stamp;
      result_d.out_code  = entry[0].code;
    end else if (cmd_i.command == CMD_INSERT) begin
      result_d.status = ST_FULL;
    end else begin
      result_d.status = ST_EMPTY;
    end
    result_d.occupancy = OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `TSQ_ASSERT_NORST(a_count_bound, clk_i, count_q <= CntW'(DEPTH))
  `TSQ_ASSERT(a_done_follows, clk_i, rst_ni, accept |=> done_o)
  `TSQ_ASSERT(a_no_spurious_done, clk_i, rst_ni, !accept |=> !done_o)
  `TSQ_ASSERT(a_empty_remove, clk_i, rst_ni,
    (accept && cmd_i.command == CMD_REMOVE && empty) |=>
    (result_o.status == ST_EMPTY && $stable(count_q)))
  `TSQ_ASSERT(a_insert_grows, clk_i, rst_ni,
    ctrl.insert |=> (count_q == $past(count_q) + 1'b1))

endmodule

// File: rtl/tsq_cell.sv
module tsq_cell (
  input  logic               clk_i,
  input  logic               occupied_i,
  input  tsq_pkg::tsq_ctrl_t ctrl_i,
  input  logic               left_gt_i,
  input  tsq_pkg::tsq_entry_t left_i,
  input  tsq_pkg::tsq_entry_t right_i,
  output logic               gt_o,
  output tsq_pkg::tsq_entry_t entry_o
);
  import tsq_pkg::*;

  tsq_entry_t entry_q, entry_d;

  // Flag cells that are empty or hold a later stamp than the new packet
  assign gt_o = !occupied_i || (entry_q.stamp > ctrl_i.entry.stamp);

  // Shift up on insert behind the slot, take new packet at the slot, shift down on remove
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && gt_o) begin
      entry_d = left_gt_i ? left_i : ctrl_i.entry;
    end else if (ctrl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: tb/sv/timestamp_sorted_queue_checker.sv
module timestamp_sorted_queue_checker #(
  parameter int unsigned DEPTH = tsq_pkg::DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  tsq_pkg::tsq_item_t   cmd_i,
  input  logic                 done_i,
  input  tsq_pkg::tsq_result_t result_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          results_owed_o,
  output int unsigned          inserts_kept_o,
  output int unsigned          inserts_dropped_o,
  output int unsigned          removes_served_o,
  output int unsigned          removes_empty_o,
  output int unsigned          peak_fill_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsq_pkg::*;

  // Shadow copy of the sorted chain, smallest stamp at slot 0
  tsq_entry_t  sorted_slots [DEPTH+1];
  int unsigned held_count = 0;

  // Results predicted for accepted transactions, oldest first
  tsq_result_t awaited_results [$];

  int unsigned mismatches = 0;
  int unsigned owed = 0;
  int unsigned kept = 0;
  int unsigned dropped = 0;
  int unsigned served = 0;
  int unsigned empties = 0;
  int unsigned peak = 0;

  assign mismatch_count_o  = mismatches;
  assign results_owed_o    = owed;
  assign inserts_kept_o    = kept;
  assign inserts_dropped_o = dropped;
  assign removes_served_o  = served;
  assign removes_empty_o   = empties;
  assign peak_fill_o       = peak;

  // Apply one command to the shadow chain and return what the block must answer
  function automatic tsq_result_t apply_command(input tsq_item_t item);
    tsq_result_t answer;
    int unsigned slot;
    int unsigned idx;
    answer = '0;
    if (item.command == CMD_INSERT) begin
      if (held_count >= DEPTH) begin
        answer.status = ST_FULL;
      end else begin
        // Place after every held stamp that is equal or smaller
        slot = 0;
        while (slot < held_count && sorted_slots[slot].stamp <= item.stamp) slot++;
        for (idx = held_count; idx > slot; idx--) sorted_slots[idx] = sorted_slots[idx-1];
        sorted_slots[slot].stamp = item.stamp;
        sorted_slots[slot].code  = item.packet_code;
        held_count++;
        answer.status = ST_INSERTED;
      end
    end else if (held_count == 0) begin
      answer.status = ST_EMPTY;
    end else begin
      // Pop the head and advance the rest by one slot
      answer.status    = ST_REMOVED;
      answer.out_stamp = sorted_slots[0].stamp;
      answer.out_code  = sorted_slots[0].code;
      for (idx = 1; idx < held_count; idx++) sorted_slots[idx-1] = sorted_slots[idx];
      held_count--;
    end
    answer.occupancy = OccW'(held_count);
    return answer;
  endfunction

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // Watch both channels: predict on each accepted transaction, check each result
  always @(posedge clk_i or negedge rst_ni) begin : watch
    tsq_result_t predicted;
    tsq_result_t oldest;
    if (!rst_ni) begin
      held_count = 0;
      awaited_results.delete();
      owed = 0;
    end else begin
      if (start_i && !busy_i) begin
        predicted = apply_command(cmd_i);
        awaited_results.push_back(predicted);
        case (predicted.status)
          ST_INSERTED: kept++;
          ST_FULL:     dropped++;
          ST_REMOVED:  served++;
          ST_EMPTY:    empties++;
          default: ;
        endcase
        if (held_count > peak) peak = held_count;
      end
      if (done_i) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, result_i);
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("status", 32'(oldest.status), 32'(result_i.status));
          compare_field("out_stamp", oldest.out_stamp, result_i.out_stamp);
          compare_field("out_code", oldest.out_code, result_i.out_code);
          compare_field("occupancy", 32'(oldest.occupancy), 32'(result_i.occupancy));
        end
      end
      owed = awaited_results.size();
    end
  end

endmodule

// File: tb/sv/timestamp_sorted_queue_core_test.sv
module timestamp_sorted_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tsq_pkg::*;

  localparam int unsigned Depth       = DefaultDepth;
  localparam int unsigned RandomCount = 1250;
  localparam int unsigned CycleLimit  = 100000;
  localparam logic [31:0] StampMax    = 32'hFFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  tsq_item_t   cmd_i;
  logic        done_o;
  tsq_result_t result_o;

  int unsigned mismatches;
  int unsigned owed;
  int unsigned kept;
  int unsigned dropped;
  int unsigned served;
  int unsigned empties;
  int unsigned peak;

  int unsigned idle_pct = 0;
  int unsigned cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  timestamp_sorted_queue_core #(
    .DEPTH (Depth)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  timestamp_sorted_queue_checker #(
    .DEPTH (Depth)
  ) u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .cmd_i             (cmd_i),
    .done_i            (done_o),
    .result_i          (result_o),
    .mismatch_count_o  (mismatches),
    .results_owed_o    (owed),
    .inserts_kept_o    (kept),
    .inserts_dropped_o (dropped),
    .removes_served_o  (served),
    .removes_empty_o   (empties),
    .peak_fill_o       (peak)
  );

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic tsq_item_t make_insert(input logic [31:0] stamp,
                                            input logic [31:0] code);
    tsq_item_t item;
    item.command     = CMD_INSERT;
    item.stamp       = stamp;
    item.packet_code = code;
    return item;
  endfunction

  // Remove carries random stamp and code, which the block must ignore
  function automatic tsq_item_t make_remove();
    tsq_item_t item;
    item.command     = CMD_REMOVE;
    item.stamp       = $urandom;
    item.packet_code = $urandom;
    return item;
  endfunction

  // Favor small and extreme stamps so ties and boundary ordering occur often
  function automatic logic [31:0] pick_stamp();
    logic [31:0] stamp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: stamp = $urandom_range(0, 7);
      4:          stamp = '0;
      5:          stamp = StampMax;
      6:          stamp = StampMax - $urandom_range(0, 3);
      default:    stamp = $urandom;
    endcase
    return stamp;
  endfunction

  // Idle at random, then hold the transaction until it is taken
  task automatic issue(input tsq_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      cmd_i <= {$urandom, $urandom, 1'($urandom)};
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (owed != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned mode;
    int unsigned burst;
    int unsigned remove_pct;
    int unsigned k;
    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Remove from an empty queue
    issue(make_remove());
    // Fill to the top with extremes and ties at low, middle and top stamps
    issue(make_insert(32'd5, 32'h0000_0000));
    issue(make_insert(32'd5, StampMax));
    issue(make_insert(32'd0, 32'hA5A5_A5A5));
    issue(make_insert(StampMax, 32'h5A5A_5A5A));
    issue(make_insert(32'd5, 32'h1234_5678));
    issue(make_insert(32'd3, 32'h8765_4321));
    issue(make_insert(32'd0, 32'h0000_0001));
    issue(make_insert(StampMax, 32'h8000_0000));
    for (k = 0; k < 8; k++) issue(make_insert(k * 32'd1000 + 32'd1, $urandom));
    // Insert on a full queue is dropped
    issue(make_insert(32'd7, 32'hDEAD_BEEF));
    // Take the head several times; ties must leave in arrival order
    repeat (5) issue(make_remove());
    drain();

    // Random bursts: fill-heavy, drain-heavy or balanced
    sent = 0;
    idle_pct = 24;
    while (sent < RandomCount) begin
      mode  = $urandom_range(0, 2);
      burst = $urandom_range(4, 40);
      remove_pct = (mode == 0) ? 20 : (mode == 1) ? 80 : 50;
      for (k = 0; k < burst && sent < RandomCount; k++) begin
        if ($urandom_range(0, 99) < remove_pct) issue(make_remove());
        else issue(make_insert(pick_stamp(), $urandom));
        sent++;
        // Switch idling at phase boundaries, after a full pause
        if (sent == RandomCount / 3) begin
          drain();
          idle_pct = 45;
        end else if (sent == 2 * RandomCount / 3) begin
          drain();
          idle_pct = 0;
        end
      end
    end

    drain();
    repeat (4) @(negedge clk_i);

    $display("Covered %0d inserts kept, %0d dropped on full, %0d removes served,",
             kept, dropped, served);
    $display("%0d removes on empty, peak occupancy %0d of %0d.", empties, peak, Depth);
    if (mismatches == 0 && owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
